// ===== design/dvrt_pkg.sv =====
package dvrt_pkg;

  // One route as it is kept in the table and reported on the result ports.
  typedef struct packed {
    logic [15:0]       addr;
    logic [7:0]        hops;
    logic [15:0]       nhop;
    logic signed [7:0] ident;
    logic [7:0]        kind;
    logic              active;
  } route_t;

  localparam int RouteW = $bits(route_t);

  // One request beat, held for the whole walk over the table.
  typedef struct packed {
    logic [1:0]        mode;
    logic [15:0]       addr;
    logic [7:0]        hops;
    logic [15:0]       nhop;
    logic signed [7:0] ident;
    logic [7:0]        kind;
    logic [15:0]       sender;
    logic [2:0]        ridx;
  } req_t;

  // Request modes.
  localparam logic [1:0] MODE_MERGE  = 2'd0;
  localparam logic [1:0] MODE_AGE    = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_READ   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SELF_ADDRESS    = 2'd0;
  localparam logic [1:0] CFG_SELF_IDENTIFIER = 2'd1;
  localparam logic [1:0] CFG_SELF_KIND       = 2'd2;

  // Result action codes.
  typedef enum logic [2:0] {
    ACT_IGNORED  = 3'd0,
    ACT_RELAXED  = 3'd1,
    ACT_KEPT     = 3'd2,
    ACT_ADDED    = 3'd3,
    ACT_DROPPED  = 3'd4,
    ACT_AGED     = 3'd5,
    ACT_ANSWERED = 3'd6
  } action_e;

  // Sequencer states: issue a slot read, then evaluate the slot.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_EVAL
  } state_e;

  localparam logic [7:0]  HOPS_INFINITE = 8'd255;
  localparam logic [7:0]  GATEWAY_KIND  = 8'd71;
  localparam logic [15:0] NULL_ADDRESS  = 16'd0;

  // Reset values of the configuration registers.
  localparam logic [15:0]       SELF_ADDRESS_RST = 16'd0;
  localparam logic signed [7:0] SELF_IDENT_RST   = 8'sd7;
  localparam logic [7:0]        SELF_KIND_RST    = 8'd71;

endpackage

// ===== design/dvrt_ram.sv =====
module dvrt_ram #(
  parameter int WIDTH = 57,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/distance_vector_route_table_top.sv =====
// Distance-vector route table.
// A request beat is taken at a rising edge with start high and busy low; its
// fields select one of four modes: merge a neighbour's entry, age the table,
// find the first gateway route, or read one slot. Each request gives exactly
// one result beat, shown for one cycle with done_o high; the receiver cannot
// hold it off, so it must take every beat.
// Slot 0 is this node and follows the configuration registers at once; the
// other slots live in a single-port-read table RAM. The sequencer walks the
// slots one at a time through one shared compare unit; for each slot it
// addresses the RAM, then compares the registered read data.
// busy stays high until the result beat is shown, so one request is in work
// at a time.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at the
// edge; the user must make them only while busy is low, since the block
// itself does not enforce it.
// Reset leaves a table with the self entry only; the RAM needs no clearing
// pass because slots at and above the entry count are never evaluated.
module distance_vector_route_table_top
  import dvrt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  // Request channel.
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        mode_i,
  input  logic [15:0]       entry_address_i,
  input  logic [7:0]        entry_hops_i,
  input  logic [15:0]       entry_next_hop_i,
  input  logic signed [7:0] entry_identifier_i,
  input  logic [7:0]        entry_kind_i,
  input  logic [15:0]       sender_address_i,
  input  logic [2:0]        read_index_i,
  // Result channel.
  output logic              done_o,
  output logic [2:0]        action_o,
  output logic [2:0]        slot_o,
  output logic              found_o,
  output logic [15:0]       route_address_o,
  output logic [7:0]        route_hops_o,
  output logic [15:0]       route_next_hop_o,
  output logic signed [7:0] route_identifier_o,
  output logic [7:0]        route_kind_o,
  output logic              route_active_o,
  output logic [3:0]        used_entries_o
);

  localparam int IW   = $clog2(TABLE_ENTRIES);
  localparam int CW   = $clog2(TABLE_ENTRIES + 1);
  localparam int IDXW = (CW > 3) ? CW : 3;
  localparam int UW   = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  // Configuration registers.
  logic [15:0]       self_addr_q;
  logic signed [7:0] self_id_q;
  logic [7:0]        self_kind_q;

  // Sequencer and table state.
  state_e          state_q, state_d;
  req_t            req_q;
  logic [IDXW-1:0] idx_q, idx_d;
  logic [CW-1:0]   count_q, count_d;

  // Result registers.
  logic            done_q, done_d;
  action_e         act_q, act_d;
  logic [IDXW-1:0] slot_q, slot_d;
  logic            found_q, found_d;
  route_t          rte_q, rte_d;

  // Table RAM ports.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  route_t            ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [RouteW-1:0] ram_rdata;

  route_t          self_rte;
  route_t          cur;
  route_t          new_rte;
  route_t          aged_rte;
  logic [7:0]      newh;
  logic [15:0]     cmp_key;
  logic [15:0]     cmp_target;
  logic            cmp_hit;
  logic            in_ignore;
  logic [IDXW-1:0] count_x;
  logic [UW-1:0]   used_w;

  dvrt_ram #(
    .WIDTH(RouteW),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      self_addr_q <= SELF_ADDRESS_RST;
      self_id_q   <= SELF_IDENT_RST;
      self_kind_q <= SELF_KIND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SELF_ADDRESS:    self_addr_q <= cfg_data_i;
        CFG_SELF_IDENTIFIER: self_id_q   <= signed'(cfg_data_i[7:0]);
        CFG_SELF_KIND:       self_kind_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // The self entry is built from the configuration registers.
  always_comb begin
    self_rte        = '0;
    self_rte.addr   = self_addr_q;
    self_rte.hops   = 8'd0;
    self_rte.nhop   = self_addr_q;
    self_rte.ident  = self_id_q;
    self_rte.kind   = self_kind_q;
    self_rte.active = 1'b1;
  end

  // Slot under evaluation: the self entry or the RAM read data.
  assign cur = (idx_q == '0) ? self_rte : route_t'(ram_rdata);

  // Offered hop count, saturating at infinity.
  assign newh = (req_q.hops == HOPS_INFINITE) ? HOPS_INFINITE : req_q.hops + 8'd1;

  // Shared compare unit: destination match for merges, gateway kind for lookups.
  assign cmp_key    = (req_q.mode == MODE_LOOKUP) ? {8'd0, cur.kind} : cur.addr;
  assign cmp_target = (req_q.mode == MODE_LOOKUP) ? {8'd0, GATEWAY_KIND} : req_q.addr;
  assign cmp_hit    = (cmp_key == cmp_target);

  // Entry that a merge appends.
  always_comb begin
    new_rte        = '0;
    new_rte.addr   = req_q.addr;
    new_rte.hops   = newh;
    new_rte.nhop   = req_q.sender;
    new_rte.ident  = req_q.ident;
    new_rte.kind   = req_q.kind;
    new_rte.active = 1'b1;
  end

  // Aging: an active slot goes inactive, an inactive one expires.
  always_comb begin
    aged_rte = cur;
    if (cur.active) begin
      aged_rte.active = 1'b0;
    end else begin
      aged_rte.hops = HOPS_INFINITE;
      aged_rte.nhop = NULL_ADDRESS;
    end
  end

  assign in_ignore = (entry_address_i == NULL_ADDRESS) || (entry_address_i == self_addr_q) ||
                     (entry_next_hop_i == self_addr_q);
  assign count_x   = IDXW'(count_q);

  // Sequencer: next state, table writes and the result beat.
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    count_d   = count_q;
    done_d    = 1'b0;
    act_d     = act_q;
    slot_d    = slot_q;
    found_d   = found_q;
    rte_d     = rte_q;
    ram_we    = 1'b0;
    ram_waddr = idx_q[IW-1:0];
    ram_wdata = cur;
    ram_raddr = idx_q[IW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (mode_i == MODE_MERGE && in_ignore) begin
            done_d  = 1'b1;
            act_d   = ACT_IGNORED;
            slot_d  = '0;
            found_d = 1'b0;
            rte_d   = '0;
          end else begin
            state_d = ST_ISSUE;
            case (mode_i)
              MODE_AGE:  idx_d = IDXW'(1);
              MODE_READ: idx_d = IDXW'(read_index_i);
              default:   idx_d = '0;
            endcase
          end
        end
      end

      ST_ISSUE: begin
        if (idx_q >= count_x) begin
          // Walk ran off the used slots.
          state_d = ST_IDLE;
          done_d  = 1'b1;
          found_d = 1'b0;
          rte_d   = '0;
          slot_d  = '0;
          unique case (req_q.mode)
            MODE_MERGE: begin
              if (count_q >= FULL_COUNT) begin
                act_d = ACT_DROPPED;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IW-1:0];
                ram_wdata = new_rte;
                count_d   = count_q + CW'(1);
                act_d     = ACT_ADDED;
                slot_d    = count_x;
                rte_d     = new_rte;
              end
            end
            MODE_AGE:    act_d = ACT_AGED;
            MODE_LOOKUP: act_d = ACT_ANSWERED;
            default: begin
              act_d  = ACT_ANSWERED;
              slot_d = IDXW'(req_q.ridx);
            end
          endcase
        end else begin
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        state_d = ST_ISSUE;
        idx_d   = idx_q + IDXW'(1);
        unique case (req_q.mode)
          MODE_MERGE: begin
            if (cmp_hit) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
              slot_d  = idx_q;
              found_d = 1'b0;
              if (newh < cur.hops) begin
                ram_we           = 1'b1;
                ram_wdata        = cur;
                ram_wdata.hops   = newh;
                ram_wdata.nhop   = req_q.sender;
                ram_wdata.active = 1'b1;
                act_d            = ACT_RELAXED;
                rte_d            = ram_wdata;
              end else begin
                act_d = ACT_KEPT;
                rte_d = cur;
              end
            end
          end
          MODE_AGE: begin
            ram_we    = 1'b1;
            ram_wdata = aged_rte;
          end
          MODE_LOOKUP: begin
            if (cmp_hit) begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
              act_d   = ACT_ANSWERED;
              slot_d  = idx_q;
              found_d = 1'b1;
              rte_d   = cur;
            end
          end
          default: begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
            act_d   = ACT_ANSWERED;
            slot_d  = idx_q;
            found_d = 1'b1;
            rte_d   = cur;
          end
        endcase
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= CW'(1);
      done_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start) begin
      req_q.mode   <= mode_i;
      req_q.addr   <= entry_address_i;
      req_q.hops   <= entry_hops_i;
      req_q.nhop   <= entry_next_hop_i;
      req_q.ident  <= entry_identifier_i;
      req_q.kind   <= entry_kind_i;
      req_q.sender <= sender_address_i;
      req_q.ridx   <= read_index_i;
    end
    act_q   <= act_d;
    slot_q  <= slot_d;
    found_q <= found_d;
    rte_q   <= rte_d;
  end

  assign used_w = UW'(count_q);

  assign busy               = (state_q != ST_IDLE);
  assign done_o             = done_q;
  assign action_o           = act_q;
  assign slot_o             = slot_q[2:0];
  assign found_o            = found_q;
  assign route_address_o    = rte_q.addr;
  assign route_hops_o       = rte_q.hops;
  assign route_next_hop_o   = rte_q.nhop;
  assign route_identifier_o = rte_q.ident;
  assign route_kind_o       = rte_q.kind;
  assign route_active_o     = rte_q.active;
  assign used_entries_o     = used_w[3:0];

`ifndef SYNTH
  // The entry count stays between the self entry alone and a full table.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CW'(1)) && (count_q <= FULL_COUNT))
    else $error("entry count out of range");

  // Only slots in use are ever evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> (idx_q < count_x))
    else $error("evaluated slot beyond entry count");

  // A result beat closes the request, so the block is free while it is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result beat shown while busy");

  // The table never shrinks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> (count_q == $past(count_q) + CW'(1)))
    else $error("entry count moved by other than one append");
`endif

endmodule

// ===== verif/tb.sv =====
module tb
  import dvrt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS       = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int END_WAIT    = 2 * SLOTS + 4;
  localparam int NUM_PHASES  = 5;
  localparam int PHASE_ITEMS = 180;
  localparam int POOL_SIZE   = 12;

  // Index 3 is not a register; a write there must leave the table alone.
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // One expected result beat.
  typedef struct packed {
    action_e     act;
    logic [2:0]  slot;
    logic        found;
    route_t      route;
    logic [3:0]  used;
  } report_t;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we_i   = 1'b0;
  logic [1:0]  cfg_idx_i  = '0;
  logic [15:0] cfg_data_i = '0;
  logic        start      = 1'b0;
  req_t        req_now    = '0;
  logic        busy;

  logic              done_o;
  logic [2:0]        action_o;
  logic [2:0]        slot_o;
  logic              found_o;
  logic [15:0]       route_address_o;
  logic [7:0]        route_hops_o;
  logic [15:0]       route_next_hop_o;
  logic signed [7:0] route_identifier_o;
  logic [7:0]        route_kind_o;
  logic              route_active_o;
  logic [3:0]        used_entries_o;

  // Shadow copy of the table and of the configuration registers.
  route_t            routes [SLOTS];
  logic [3:0]        used_count;
  logic [15:0]       self_addr;
  logic signed [7:0] self_ident;
  logic [7:0]        self_kind;

  req_t        requests_pending [$];
  report_t     reports_due [$];
  logic [15:0] addr_pool [POOL_SIZE];
  int          gap_pct     = 0;
  int          gap_left    = 0;
  int          mismatches  = 0;
  int          idle_cycles = 0;

  distance_vector_route_table_top #(
    .TABLE_ENTRIES(SLOTS)
  ) DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .start             (start),
    .busy              (busy),
    .mode_i            (req_now.mode),
    .entry_address_i   (req_now.addr),
    .entry_hops_i      (req_now.hops),
    .entry_next_hop_i  (req_now.nhop),
    .entry_identifier_i(req_now.ident),
    .entry_kind_i      (req_now.kind),
    .sender_address_i  (req_now.sender),
    .read_index_i      (req_now.ridx),
    .done_o            (done_o),
    .action_o          (action_o),
    .slot_o            (slot_o),
    .found_o           (found_o),
    .route_address_o   (route_address_o),
    .route_hops_o      (route_hops_o),
    .route_next_hop_o  (route_next_hop_o),
    .route_identifier_o(route_identifier_o),
    .route_kind_o      (route_kind_o),
    .route_active_o    (route_active_o),
    .used_entries_o    (used_entries_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Slot 0 always mirrors the node's own registers.
  function automatic void write_self();
    routes[0] = '{addr: self_addr, hops: 8'd0, nhop: self_addr, ident: self_ident,
                  kind: self_kind, active: 1'b1};
  endfunction

  function automatic void reset_routes();
    self_addr  = SELF_ADDRESS_RST;
    self_ident = SELF_IDENT_RST;
    self_kind  = SELF_KIND_RST;
    for (int i = 0; i < SLOTS; i++) routes[i] = '0;
    used_count = 4'd1;
    write_self();
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [15:0] data);
    case (idx)
      CFG_SELF_ADDRESS:    self_addr = data;
      CFG_SELF_IDENTIFIER: self_ident = data[7:0];
      CFG_SELF_KIND:       self_kind = data[7:0];
      default: ;
    endcase
    write_self();
  endfunction

  // Works out the result of one request and updates the shadow table.
  function automatic report_t update_routes(req_t r);
    report_t    rep;
    logic [7:0] new_hops;
    int         hit;
    rep = '{act: ACT_ANSWERED, slot: 3'd0, found: 1'b0, route: '0, used: 4'd0};
    hit = -1;
    case (r.mode)
      MODE_MERGE: begin
        new_hops = (r.hops == HOPS_INFINITE) ? HOPS_INFINITE : r.hops + 8'd1;
        if (r.addr == NULL_ADDRESS || r.addr == self_addr || r.nhop == self_addr) begin
          rep.act = ACT_IGNORED;
        end else begin
          for (int i = 0; i < used_count; i++)
            if (hit < 0 && routes[i].addr == r.addr) hit = i;
          if (hit >= 0) begin
            // Known destination: take the sender's route only if strictly shorter.
            if (new_hops < routes[hit].hops) begin
              routes[hit].hops   = new_hops;
              routes[hit].nhop   = r.sender;
              routes[hit].active = 1'b1;
              rep.act = ACT_RELAXED;
            end else begin
              rep.act = ACT_KEPT;
            end
            rep.slot  = 3'(hit);
            rep.route = routes[hit];
          end else if (used_count >= SLOTS) begin
            rep.act = ACT_DROPPED;
          end else begin
            routes[used_count] = '{addr: r.addr, hops: new_hops, nhop: r.sender,
                                   ident: r.ident, kind: r.kind, active: 1'b1};
            rep.act    = ACT_ADDED;
            rep.slot   = used_count[2:0];
            rep.route  = routes[used_count];
            used_count = used_count + 4'd1;
          end
        end
      end
      MODE_AGE: begin
        // Active routes go inactive; routes already inactive expire.
        for (int i = 1; i < used_count; i++) begin
          if (routes[i].active) begin
            routes[i].active = 1'b0;
          end else begin
            routes[i].hops = HOPS_INFINITE;
            routes[i].nhop = NULL_ADDRESS;
          end
        end
        rep.act = ACT_AGED;
      end
      MODE_LOOKUP: begin
        for (int i = 0; i < used_count; i++)
          if (hit < 0 && routes[i].kind == GATEWAY_KIND) hit = i;
        if (hit >= 0) begin
          rep.slot  = 3'(hit);
          rep.found = 1'b1;
          rep.route = routes[hit];
        end
      end
      default: begin
        rep.slot = r.ridx;
        if (r.ridx < used_count) begin
          rep.found = 1'b1;
          rep.route = routes[r.ridx];
        end
      end
    endcase
    rep.used = used_count;
    return rep;
  endfunction

  function automatic req_t make_request(logic [1:0] mode, logic [15:0] addr,
                                        logic [7:0] hops, logic [15:0] nhop,
                                        logic signed [7:0] ident, logic [7:0] kind,
                                        logic [15:0] sender, logic [2:0] ridx);
    req_t r;
    r = '{mode: mode, addr: addr, hops: hops, nhop: nhop, ident: ident, kind: kind,
          sender: sender, ridx: ridx};
    return r;
  endfunction

  // Mostly merges of known destinations so that relax and keep paths see heavy use;
  // the rest is ticks, lookups, reads, random-address and malformed merges.
  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.addr   = 16'($urandom);
    r.hops   = 8'($urandom);
    r.nhop   = 16'($urandom);
    r.ident  = 8'($urandom);
    r.kind   = 8'($urandom);
    r.sender = 16'($urandom);
    r.ridx   = 3'($urandom);
    pick = $urandom_range(99);
    if (pick < 55) r.mode = MODE_MERGE;
    else if (pick < 65) r.mode = MODE_AGE;
    else if (pick < 80) r.mode = MODE_LOOKUP;
    else r.mode = MODE_READ;
    if (r.mode == MODE_MERGE) begin
      pick = $urandom_range(99);
      if (pick < 70) r.addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 75) r.addr = NULL_ADDRESS;
      else if (pick < 80) r.addr = self_addr;
      if ($urandom_range(19) == 0) r.nhop = self_addr;
      pick = $urandom_range(9);
      if (pick < 5) r.hops = 8'($urandom_range(12));
      else if (pick < 6) r.hops = 8'($urandom_range(255, 250));
      if ($urandom_range(3) == 0) r.kind = GATEWAY_KIND;
    end
    return r;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Returns once every queued request has been taken and every result has come back.
  // The checks are made at the falling edge, where the driver's updates have settled.
  task automatic drain();
    while (requests_pending.size() != 0 || start || reports_due.size() != 0)
      @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  // Request driver: holds a beat until it is taken, idles in random bursts.
  always @(posedge clk_i) begin : drive_requests
    if (rst_ni) begin
      if (start && !busy) reports_due.push_back(update_routes(req_now));
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (requests_pending.size() != 0 && $urandom_range(99) < gap_pct) begin
          gap_left <= $urandom_range(8);
          start    <= 1'b0;
        end else if (requests_pending.size() != 0) begin
          req_now <= requests_pending.pop_front();
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every beat is compared with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    report_t want;
    if (rst_ni && done_o) begin
      if (reports_due.size() == 0) begin
        $error("result beat with no request outstanding");
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        check_field("action", 16'(want.act), 16'(action_o));
        check_field("slot", 16'(want.slot), 16'(slot_o));
        check_field("found", 16'(want.found), 16'(found_o));
        check_field("route_address", want.route.addr, route_address_o);
        check_field("route_hops", 16'(want.route.hops), 16'(route_hops_o));
        check_field("route_next_hop", want.route.nhop, route_next_hop_o);
        check_field("route_identifier", 16'(unsigned'(want.route.ident)),
                    16'(unsigned'(route_identifier_o)));
        check_field("route_kind", 16'(want.route.kind), 16'(route_kind_o));
        check_field("route_active", 16'(want.route.active), 16'(route_active_o));
        check_field("used_entries", 16'(want.used), 16'(used_entries_o));
      end
    end
  end

  // Watchdog: too long without a request or a result beat ends the run.
  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || done_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("distance_vector_route_table_top: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [15:0]       phase_addr [NUM_PHASES];
    logic signed [7:0] phase_ident [NUM_PHASES];
    logic [7:0]        phase_kind [NUM_PHASES];
    int                phase_gap [NUM_PHASES];
    addr_pool   = '{16'h1234, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA,
                    16'h7FFF, 16'h4321, 16'h00A5, 16'h0100, 16'hBEEF, 16'h0002};
    phase_addr  = '{16'hFFFF, 16'h0000, 16'($urandom), 16'h1234, 16'($urandom)};
    phase_ident = '{8'sd127, -8'sd128, 8'($urandom), 8'sd0, 8'($urandom)};
    phase_kind  = '{GATEWAY_KIND, 8'd255, 8'($urandom), 8'd0, 8'($urandom)};
    phase_gap   = '{30, 0, 50, 20, 0};
    reset_routes();
    gap_pct = 40;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: self entry read back, found as gateway, empty slot read.
    requests_pending.push_back(make_request(MODE_READ, '0, '0, '0, '0, '0, '0, 3'd0));
    requests_pending.push_back(make_request(MODE_LOOKUP, '0, '0, '0, '0, '0, '0, 3'd0));
    requests_pending.push_back(make_request(MODE_READ, '0, '0, '0, '0, '0, '0, 3'd7));
    drain();

    write_reg(CFG_SELF_ADDRESS, 16'h00A5);
    write_reg(CFG_SELF_IDENTIFIER, {8'($urandom), 8'h80});
    write_reg(CFG_SELF_KIND, {8'($urandom), 8'h20});
    write_reg(CFG_UNUSED, 16'($urandom));

    // Ignored merges: null address, own address, own next hop; then a lookup miss.
    requests_pending.push_back(make_request(MODE_MERGE, NULL_ADDRESS, 8'd1, 16'hFFFF,
                                            8'sd1, 8'd1, 16'h0001, 3'd0));
    requests_pending.push_back(make_request(MODE_MERGE, 16'h00A5, 8'd1, 16'hFFFF,
                                            8'sd1, 8'd1, 16'h0001, 3'd0));
    requests_pending.push_back(make_request(MODE_MERGE, 16'h1234, 8'd1, 16'h00A5,
                                            8'sd1, 8'd1, 16'h0001, 3'd0));
    requests_pending.push_back(make_request(MODE_LOOKUP, '0, '0, '0, '0, '0, '0, 3'd0));
    // Add, relax, keep, then a saturated add that a shorter claim cannot beat.
    requests_pending.push_back(make_request(MODE_MERGE, 16'h1234, 8'd3, 16'hFFFF,
                                            8'sd127, GATEWAY_KIND, 16'hFFFF, 3'd7));
    requests_pending.push_back(make_request(MODE_MERGE, 16'h1234, 8'd0, 16'h0000,
                                            8'sd0, 8'd0, 16'h0001, 3'd0));
    requests_pending.push_back(make_request(MODE_MERGE, 16'h1234, 8'd5, 16'h0000,
                                            8'sd0, 8'd0, 16'h0002, 3'd0));
    requests_pending.push_back(make_request(MODE_MERGE, 16'hFFFF, 8'd255, 16'h0000,
                                            -8'sd128, 8'd255, 16'h0000, 3'd0));
    requests_pending.push_back(make_request(MODE_MERGE, 16'hFFFF, 8'd254, 16'h0000,
                                            8'sd0, 8'd0, 16'h0003, 3'd0));
    requests_pending.push_back(make_request(MODE_LOOKUP, '0, '0, '0, '0, '0, '0, 3'd0));
    // Two ticks expire every route but slot 0; a claim under 254 hops then relaxes one.
    requests_pending.push_back(make_request(MODE_AGE, '0, '0, '0, '0, '0, '0, 3'd0));
    requests_pending.push_back(make_request(MODE_AGE, '0, '0, '0, '0, '0, '0, 3'd0));
    requests_pending.push_back(make_request(MODE_READ, '0, '0, '0, '0, '0, '0, 3'd1));
    requests_pending.push_back(make_request(MODE_MERGE, 16'h1234, 8'd10, 16'h0000,
                                            8'sd0, 8'd0, 16'h5A5A, 3'd0));
    // Fill the table, then one destination too many.
    for (int i = 2; i < 7; i++)
      requests_pending.push_back(make_request(MODE_MERGE, addr_pool[i], 8'($urandom),
                                              16'h0000, 8'($urandom), 8'($urandom),
                                              16'($urandom), 3'd0));
    requests_pending.push_back(make_request(MODE_MERGE, 16'h4321, 8'd2, 16'h0000,
                                            8'sd5, 8'd5, 16'h0005, 3'd0));
    requests_pending.push_back(make_request(MODE_READ, '0, '0, '0, '0, '0, '0, 3'd7));
    requests_pending.push_back(make_request(MODE_READ, '0, '0, '0, '0, '0, '0, 3'd0));
    drain();

    // Random phases, each under its own node configuration; the last has no idling.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_SELF_ADDRESS, phase_addr[p]);
      write_reg(CFG_SELF_IDENTIFIER, {8'($urandom), phase_ident[p]});
      write_reg(CFG_SELF_KIND, {8'($urandom), phase_kind[p]});
      write_reg(CFG_UNUSED, 16'($urandom));
      gap_pct = phase_gap[p];
      for (int n = 0; n < PHASE_ITEMS; n++) requests_pending.push_back(random_request());
      drain();
    end

    repeat (END_WAIT) @(posedge clk_i);
    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("distance_vector_route_table_top: match");
    end else begin
      $display("distance_vector_route_table_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/dvrt_pkg.sv
design/dvrt_ram.sv
design/distance_vector_route_table_top.sv
verif/tb.sv
